// ===== sv/fps_pkg.sv =====
// Shared constants, types and helpers of the farthest point sampler.
`timescale 1ns / 1ps
package fps_pkg;
	localparam int MAX_POINTS  = 1024;
	localparam int MAX_SAMPLES = 64;
	localparam int DIM         = 3;
	localparam int COORD_BITS  = 16;
	localparam int COORD_W     = 16;
	localparam int START_W     = 12;
	localparam int NS_W        = 7;
	localparam int IDX_W       = 10;
	localparam int DIST_W      = 37;
	localparam int SQ_W        = 33;
	localparam int ADDR_W      = $clog2(MAX_POINTS);
	localparam int CNT_W       = $clog2(MAX_POINTS + 1);
	localparam int CMP_W       = (CNT_W > START_W) ? CNT_W : START_W;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic [DIST_W-1:0] DIST_FULL = {DIST_W{1'b1}};

	typedef logic signed [COORD_W-1:0] coord_t;

	// One stored point: sample mask bit and its coordinates.
	typedef struct packed {
		logic                    ok;
		logic [DIM-1:0][COORD_W-1:0] crd;
	} point_t;

	// One command from the front to the engine.
	typedef struct packed {
		logic              wr;
		logic [ADDR_W-1:0] addr;
		point_t            pt;
		logic              job;
		logic [CNT_W-1:0]  n;
		logic [CNT_W-1:0]  vcount;
		logic [ADDR_W-1:0] start;
		logic [NS_W-1:0]   k;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// Keep the low COORD_BITS bits, sign-extended to the full width.
	function automatic coord_t sext_coord(input logic [COORD_W-1:0] v);
		coord_t r;
		r = $signed(v << (COORD_W - COORD_BITS)) >>> (COORD_W - COORD_BITS);
		return r;
	endfunction
endpackage

// ===== sv/fps_queue.sv =====
// Short command queue between the front and the sampling engine.
`timescale 1ns / 1ps
module fps_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fps_pkg::entry_t push_data,
	input  logic            pop,
	output fps_pkg::entry_t head,
	output fps_pkg::qstat_t stat
);
	import fps_pkg::*;

	entry_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// ===== sv/fps_front.sv =====
// Input front: counts points, zeroes an out-of-range start index, caps the sample count and issues commands.
`timescale 1ns / 1ps
module fps_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [fps_pkg::COORD_W-1:0] coord_0,
	input  logic [fps_pkg::COORD_W-1:0] coord_1,
	input  logic [fps_pkg::COORD_W-1:0] coord_2,
	input  logic [fps_pkg::COORD_W-1:0] coord_3,
	input  logic                        point_ok,
	input  logic                        last_point,
	input  logic [fps_pkg::START_W-1:0] start_index,
	input  logic [fps_pkg::NS_W-1:0]    num_samples,
	input  fps_pkg::qstat_t             qstat,
	output logic                        push,
	output fps_pkg::entry_t             push_data
);
	import fps_pkg::*;

	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        vcount_q;
	logic [3:0][COORD_W-1:0] raw;
	logic                    accept;
	logic                    stored;
	logic [CNT_W-1:0]        n_new;
	logic [CNT_W-1:0]        v_new;
	logic                    start_ok;

	assign raw      = {coord_3, coord_2, coord_1, coord_0};
	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;
	assign stored   = (count_q < CNT_W'(MAX_POINTS));
	assign n_new    = count_q + CNT_W'(stored);
	assign v_new    = vcount_q + CNT_W'(stored && point_ok);
	assign start_ok = !start_index[START_W-1] &&
		(CMP_W'(start_index[START_W-2:0]) < CMP_W'(n_new));
	assign push     = accept && (stored || last_point);

	always_comb begin
		push_data.wr   = stored;
		push_data.addr = ADDR_W'(count_q);
		push_data.pt.ok = point_ok;
		for (int d = 0; d < DIM; d++) begin
			push_data.pt.crd[d] = sext_coord(raw[d]);
		end
		push_data.job    = last_point;
		push_data.n      = n_new;
		push_data.vcount = v_new;
		push_data.start  = start_ok ? ADDR_W'(start_index[START_W-2:0]) : '0;
		push_data.k      = (num_samples > NS_W'(MAX_SAMPLES)) ? NS_W'(MAX_SAMPLES)
			: num_samples;
	end

	// Restart the count after each closing item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			vcount_q <= '0;
		end else if (accept) begin
			if (last_point) begin
				count_q  <= '0;
				vcount_q <= '0;
			end else begin
				count_q  <= n_new;
				vcount_q <= v_new;
			end
		end
	end
endmodule

// ===== sv/fps_engine.sv =====
// Sampling engine: point and distance memories, sweep pipeline, result register.
`timescale 1ns / 1ps
module fps_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fps_pkg::entry_t           head,
	input  fps_pkg::qstat_t           qstat,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [fps_pkg::IDX_W-1:0] sample_index,
	output logic                      sample_last
);
	import fps_pkg::*;

	typedef enum logic [5:0] {
		E_IDLE  = 6'b000001,
		E_EMIT  = 6'b000010,
		E_FETCH = 6'b000100,
		E_LATCH = 6'b001000,
		E_SWEEP = 6'b010000,
		E_DRAIN = 6'b100000
	} estate_t;

	typedef struct packed {
		logic              free;
		logic [DIST_W-1:0] dmin;
	} dstate_t;

	point_t  pt_mem [MAX_POINTS];
	dstate_t ds_mem [MAX_POINTS];

	estate_t           state_q;
	logic [ADDR_W-1:0] pick_q;
	logic [CNT_W-1:0]  n_q;
	logic [NS_W-1:0]   k_q;
	logic [NS_W-1:0]   eff_q;
	logic [NS_W-1:0]   cnt_q;
	logic [NS_W-1:0]   i_q;
	logic [ADDR_W-1:0] issue_q;
	logic              first_q;
	logic [DIM-1:0][COORD_W-1:0] pick_crd_q;
	point_t            pt_rd_q;
	dstate_t           ds_rd_q;
	logic [ADDR_W-1:0] rd_addr;

	logic              v_s1, v_s2, v_s3;
	logic [ADDR_W-1:0] j_s1, j_s2, j_s3;
	logic              free_s2, free_s3;
	logic [DIST_W-1:0] dist_s2, dist_s3, dd_s3;
	logic [DIM-1:0][SQ_W-1:0] sq_s2;

	logic              have_q;
	logic [DIST_W-1:0] best_q;
	logic [ADDR_W-1:0] best_idx_q;

	logic              out_valid_q;
	logic [IDX_W-1:0]  idx_q;
	logic              last_q;

	logic              free1;
	logic [DIST_W-1:0] dist1;
	logic [DIST_W-1:0] dd_sum;
	logic [DIST_W-1:0] nd;
	logic              cand;
	logic              out_free;
	logic              final_emit;
	logic [CNT_W-1:0]  eff_full;

	assign out_valid    = out_valid_q;
	assign sample_index = idx_q;
	assign sample_last  = last_q;
	assign out_free     = !out_valid_q || !out_stall;
	assign pop          = (state_q == E_IDLE) && !qstat.empty;
	assign rd_addr      = (state_q == E_FETCH) ? pick_q : issue_q;
	assign final_emit   = ((cnt_q + 1'b1) == k_q);
	assign eff_full     = (head.vcount < CNT_W'(head.k)) ? head.vcount : CNT_W'(head.k);

	// Point store: written from the queue, read for the pick and the sweep.
	always_ff @(posedge clk) begin
		if (pop && head.wr) begin
			pt_mem[head.addr] <= head.pt;
		end
		pt_rd_q <= pt_mem[rd_addr];
	end

	// Nearest-distance store: read at issue, written back at the last stage.
	always_ff @(posedge clk) begin
		if (v_s3) begin
			ds_mem[j_s3] <= '{free: free_s3 && (j_s3 != pick_q), dmin: nd};
		end
		ds_rd_q <= ds_mem[issue_q];
	end

	// First sweep of a set sees every valid point free and at full distance.
	assign free1 = first_q ? pt_rd_q.ok : ds_rd_q.free;
	assign dist1 = first_q ? DIST_FULL : ds_rd_q.dmin;

	always_comb begin
		dd_sum = '0;
		for (int d = 0; d < DIM; d++) begin
			dd_sum = dd_sum + DIST_W'(sq_s2[d]);
		end
	end

	assign nd   = (free_s3 && (dd_s3 < dist_s3)) ? dd_s3 : dist_s3;
	assign cand = v_s3 && free_s3 && (j_s3 != pick_q);

	// Sweep pipeline: squares, sum, then min and running best.
	always_ff @(posedge clk) begin
		logic signed [COORD_W:0]     diff;
		logic signed [2*COORD_W+1:0] prod;
		j_s1 <= issue_q;
		for (int d = 0; d < DIM; d++) begin
			diff = $signed({pt_rd_q.crd[d][COORD_W-1], pt_rd_q.crd[d]})
				- $signed({pick_crd_q[d][COORD_W-1], pick_crd_q[d]});
			prod = diff * diff;
			sq_s2[d] <= prod[SQ_W-1:0];
		end
		j_s2    <= j_s1;
		free_s2 <= free1;
		dist_s2 <= dist1;
		j_s3    <= j_s2;
		free_s3 <= free_s2;
		dist_s3 <= dist_s2;
		dd_s3   <= dd_sum;
		if (state_q == E_LATCH) begin
			pick_crd_q <= pt_rd_q.crd;
		end
		if (cand && (!have_q || nd > best_q)) begin
			best_q     <= nd;
			best_idx_q <= j_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= E_IDLE;
			pick_q      <= '0;
			n_q         <= '0;
			k_q         <= '0;
			eff_q       <= '0;
			cnt_q       <= '0;
			i_q         <= '0;
			issue_q     <= '0;
			first_q     <= 1'b0;
			have_q      <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			last_q      <= 1'b0;
		end else begin
			v_s1 <= (state_q == E_SWEEP);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cand) begin
				have_q <= 1'b1;
			end
			// Load a new result when the register is free, else hold it.
			if (out_free) begin
				out_valid_q <= (state_q == E_EMIT);
			end
			case (state_q)
				E_IDLE: begin
					if (pop && head.job) begin
						pick_q  <= head.start;
						n_q     <= head.n;
						k_q     <= head.k;
						eff_q   <= NS_W'(eff_full);
						cnt_q   <= '0;
						i_q     <= '0;
						first_q <= 1'b1;
						if (head.k != '0) begin
							state_q <= E_EMIT;
						end
					end
				end
				E_EMIT: begin
					if (out_free) begin
						idx_q       <= IDX_W'(pick_q);
						last_q      <= final_emit;
						cnt_q       <= cnt_q + 1'b1;
						if (final_emit) begin
							state_q <= E_IDLE;
						end else if ((i_q + 1'b1) < eff_q) begin
							i_q     <= i_q + 1'b1;
							state_q <= E_FETCH;
						end
					end
				end
				E_FETCH: begin
					state_q <= E_LATCH;
				end
				E_LATCH: begin
					issue_q <= '0;
					have_q  <= 1'b0;
					state_q <= E_SWEEP;
				end
				E_SWEEP: begin
					if (CNT_W'(issue_q) == (n_q - 1'b1)) begin
						state_q <= E_DRAIN;
					end else begin
						issue_q <= issue_q + 1'b1;
					end
				end
				E_DRAIN: begin
					// Take the winner once the last point leaves the pipeline.
					if (!v_s1 && !v_s2 && !v_s3) begin
						pick_q  <= best_idx_q;
						first_q <= 1'b0;
						state_q <= E_EMIT;
					end
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== sv/farthest_point_sampler.sv =====
// Top level of the farthest point sampler: config register, front, queue, engine.
// Loading: one point per cycle while in_stall is low; a four-deep queue decouples front and engine.
// Sampling: after the closing item, the start point is the first pick; each further pick sweeps all n
// stored points, and once the valid points run out the last pick repeats until k samples are out.
// The sweep reads one stored point per cycle from a single read port of the point memory.
// Reset clears counters, control and the output register, sets num_samples to 16;
// the point and distance memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module farthest_point_sampler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [fps_pkg::COORD_W-1:0] coord_0,
	input  logic [fps_pkg::COORD_W-1:0] coord_1,
	input  logic [fps_pkg::COORD_W-1:0] coord_2,
	input  logic [fps_pkg::COORD_W-1:0] coord_3,
	input  logic                        point_ok,
	input  logic                        last_point,
	input  logic [fps_pkg::START_W-1:0] start_index,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [fps_pkg::IDX_W-1:0]   sample_index,
	output logic                        sample_last,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [fps_pkg::NS_W-1:0]    num_samples
);
	import fps_pkg::*;

	logic [NS_W-1:0] num_samples_q;
	logic            push;
	entry_t          push_data;
	entry_t          head;
	qstat_t          qstat;
	logic            pop;

	// Accept a config transfer in any cycle; the user must issue it only while idle, the block does not enforce this.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_samples_q <= NS_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			num_samples_q <= num_samples;
		end
	end

	// Front: count points, zero an out-of-range start, push write/job commands.
	fps_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.coord_0     (coord_0),
		.coord_1     (coord_1),
		.coord_2     (coord_2),
		.coord_3     (coord_3),
		.point_ok    (point_ok),
		.last_point  (last_point),
		.start_index (start_index),
		.num_samples (num_samples_q),
		.qstat       (qstat),
		.push        (push),
		.push_data   (push_data)
	);

	// Hold commands while the engine sweeps.
	fps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (qstat)
	);

	// Engine: store points, run the sweeps, drive each result transfer.
	fps_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_index (sample_index),
		.sample_last  (sample_last)
	);
endmodule
